// File: rtl/lshs_pkg.sv
`timescale 1ns / 1ps

package lshs_pkg;

   localparam int POS_BITS_DEFAULT   = 32;
   localparam int TIMER_BITS_DEFAULT = 24;

   localparam int HALF_W   = 24;
   localparam int OUT_W    = 32;
   localparam int CSR_W    = 32;
   localparam int CSR_AW   = 3;

   localparam logic [HALF_W-1:0] HALF_PERIOD_RESET = 24'd5000;
   localparam logic LIMITS_RESET = 1'b1;

   localparam logic REG_HALF_PERIOD = 1'b0;
   localparam logic REG_LIMITS      = 1'b1;

   localparam logic [1:0] OP_TICK      = 2'd0;
   localparam logic [1:0] OP_HOME      = 2'd1;
   localparam logic [1:0] OP_FIND_END  = 2'd2;
   localparam logic [1:0] OP_CALIBRATE = 2'd3;

   localparam logic [1:0] ST_NONE      = 2'd0;
   localparam logic [1:0] ST_DONE      = 2'd1;
   localparam logic [1:0] ST_NO_LIMITS = 2'd2;
   localparam logic [1:0] ST_BUSY      = 2'd3;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_SEEK_HOME,
      PH_CLEAR_HOME,
      PH_SEEK_END
   } phase_type;

   typedef struct packed {
      logic [HALF_W-1:0] half_period_ticks;
      logic              limits_present;
   } cfg_type;

   typedef struct packed {
      logic                    step_out;
      logic                    dir_out;
      logic signed [OUT_W-1:0] position;
      logic signed [OUT_W-1:0] end_position;
      logic                    busy_res;
      logic [1:0]              status;
   } result_type;

endpackage

// File: rtl/limit_switch_homing_sequencer_top.sv
`timescale 1ns / 1ps

// Homing sequencer for one stepper axis: every request item is one time tick that may carry a
// command (home, find end, calibrate) and the levels of the active-low home and end sensors, and
// produces exactly one response item with the step and direction levels, position, recorded end
// position, busy flag and status. Items flow at one per clock unless responses stall: one
// input register, one pass through the sequencer logic, and one response register that holds a
// stalled response while one more request can still be taken into the input register. The step
// timing counts ticks, so a tick should be sent every clock when step timing is to be exact.
// The half period and limit enable are set through the register port; the user must write them
// only while no item is in flight, which the block does not enforce. Clearing the limit enable
// only rejects new commands; a new half period applies at a running sequence's next reload.

module limit_switch_homing_sequencer_top #(
   parameter int POS_BITS   = lshs_pkg::POS_BITS_DEFAULT,
   parameter int TIMER_BITS = lshs_pkg::TIMER_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,

   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [1:0]                       req_op,
   input  logic                             req_home_sensor,
   input  logic                             req_end_sensor,

   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_step_out,
   output logic                             rsp_dir_out,
   output logic signed [lshs_pkg::OUT_W-1:0] rsp_position,
   output logic signed [lshs_pkg::OUT_W-1:0] rsp_end_position,
   output logic                             rsp_busy_res,
   output logic [1:0]                       rsp_status,

   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [lshs_pkg::CSR_AW-1:0]      csr_paddr,
   input  logic [lshs_pkg::CSR_W-1:0]       csr_pwdata,
   output logic [lshs_pkg::CSR_W-1:0]       csr_prdata,
   output logic                             csr_pready
);

   lshs_pkg::cfg_type    cfg;
   lshs_pkg::result_type result;
   lshs_pkg::result_type out_ff;

   logic       in_valid_ff;
   logic       in_valid_in;
   logic [1:0] in_op_ff;
   logic       in_home_ff;
   logic       in_end_ff;
   logic       out_valid_ff;
   logic       out_valid_in;
   logic       out_free;
   logic       fire;
   logic       req_take;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take || (in_valid_ff && !fire);
   assign out_valid_in = fire || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_op_ff   <= req_op;
         in_home_ff <= req_home_sensor;
         in_end_ff  <= req_end_sensor;
      end
      if (fire) begin
         out_ff <= result;
      end
   end

   lshs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   lshs_engine #(
      .POS_BITS   (POS_BITS),
      .TIMER_BITS (TIMER_BITS)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .op          (in_op_ff),
      .home_sensor (in_home_ff),
      .end_sensor  (in_end_ff),
      .cfg         (cfg),
      .result      (result)
   );

   assign rsp_valid        = out_valid_ff;
   assign rsp_step_out     = out_ff.step_out;
   assign rsp_dir_out      = out_ff.dir_out;
   assign rsp_position     = out_ff.position;
   assign rsp_end_position = out_ff.end_position;
   assign rsp_busy_res     = out_ff.busy_res;
   assign rsp_status       = out_ff.status;

endmodule

// File: rtl/lshs_csr.sv
`timescale 1ns / 1ps

module lshs_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [lshs_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [lshs_pkg::CSR_W-1:0]    csr_pwdata,
   output logic [lshs_pkg::CSR_W-1:0]    csr_prdata,
   output logic                          csr_pready,
   output lshs_pkg::cfg_type             cfg
);

   logic [lshs_pkg::HALF_W-1:0] half_ff;
   logic [lshs_pkg::HALF_W-1:0] half_in;
   logic                        limits_ff;
   logic                        limits_in;
   logic                        wr_en;
   logic                        reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_sel    = csr_paddr[2];

   always_comb begin
      half_in   = half_ff;
      limits_in = limits_ff;
      if (wr_en) begin
         unique case (reg_sel)
            lshs_pkg::REG_HALF_PERIOD: half_in   = csr_pwdata[lshs_pkg::HALF_W-1:0];
            lshs_pkg::REG_LIMITS:      limits_in = csr_pwdata[0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff   <= lshs_pkg::HALF_PERIOD_RESET;
         limits_ff <= lshs_pkg::LIMITS_RESET;
      end else begin
         half_ff   <= half_in;
         limits_ff <= limits_in;
      end
   end

   always_comb begin
      unique case (reg_sel)
         lshs_pkg::REG_HALF_PERIOD:
            csr_prdata = lshs_pkg::CSR_W'(half_ff);
         lshs_pkg::REG_LIMITS:
            csr_prdata = lshs_pkg::CSR_W'(limits_ff);
      endcase
   end

   assign cfg.half_period_ticks = half_ff;
   assign cfg.limits_present    = limits_ff;

endmodule

// File: rtl/lshs_engine.sv
`timescale 1ns / 1ps

module lshs_engine #(
   parameter int POS_BITS   = lshs_pkg::POS_BITS_DEFAULT,
   parameter int TIMER_BITS = lshs_pkg::TIMER_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  logic [1:0]           op,
   input  logic                 home_sensor,
   input  logic                 end_sensor,
   input  lshs_pkg::cfg_type    cfg,
   output lshs_pkg::result_type result
);

   localparam int CMP_W = (TIMER_BITS > lshs_pkg::HALF_W) ? TIMER_BITS : lshs_pkg::HALF_W;
   localparam logic signed [POS_BITS-1:0] POS_MAX = {1'b0, {(POS_BITS-1){1'b1}}};
   localparam logic signed [POS_BITS-1:0] POS_MIN = {1'b1, {(POS_BITS-1){1'b0}}};
   localparam logic signed [POS_BITS-1:0] POS_ONE = POS_BITS'(1);
   localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};
   localparam logic [TIMER_BITS-1:0] TIMER_ONE = TIMER_BITS'(1);

   lshs_pkg::phase_type          phase_ff;
   lshs_pkg::phase_type          phase_in;
   logic signed [POS_BITS-1:0]   pos_ff;
   logic signed [POS_BITS-1:0]   pos_in;
   logic signed [POS_BITS-1:0]   end_pos_ff;
   logic signed [POS_BITS-1:0]   end_pos_in;
   logic [TIMER_BITS-1:0]        timer_ff;
   logic [TIMER_BITS-1:0]        timer_in;
   logic                         level_ff;
   logic                         level_in;
   logic                         dir_ff;
   logic                         dir_in;
   logic                         pend_ff;
   logic                         pend_in;

   logic                         cmd;
   logic                         busy;
   logic                         accepted;
   logic                         tick;
   logic                         tick_done;
   logic [CMP_W-1:0]             half_ext;
   logic [TIMER_BITS-1:0]        half_load;
   logic [TIMER_BITS-1:0]        timer_dec;
   logic signed [POS_BITS-1:0]   moved_pos;
   logic [1:0]                   status;

   assign cmd      = (op != lshs_pkg::OP_TICK);
   assign busy     = (phase_ff != lshs_pkg::PH_IDLE);
   assign accepted = cmd && cfg.limits_present && !busy;
   assign tick     = !accepted && busy;

   assign half_ext  = CMP_W'(cfg.half_period_ticks);
   assign half_load = (cfg.half_period_ticks == '0) ? TIMER_ONE :
                      (half_ext > CMP_W'(TIMER_MAX)) ? TIMER_MAX :
                      TIMER_BITS'(half_ext);

   assign timer_dec = (timer_ff != '0) ? (timer_ff - TIMER_ONE) : '0;

   always_comb begin
      if (dir_ff) begin
         moved_pos = (pos_ff < POS_MAX) ? (pos_ff + POS_ONE) : pos_ff;
      end else begin
         moved_pos = (pos_ff > POS_MIN) ? (pos_ff - POS_ONE) : pos_ff;
      end
   end

   always_comb begin
      phase_in   = phase_ff;
      pos_in     = pos_ff;
      end_pos_in = end_pos_ff;
      timer_in   = timer_ff;
      level_in   = level_ff;
      dir_in     = dir_ff;
      pend_in    = pend_ff;
      tick_done  = 1'b0;
      if (accepted) begin
         level_in = 1'b0;
         timer_in = '0;
         if (op == lshs_pkg::OP_FIND_END) begin
            pend_in = 1'b0;
            if (!end_sensor) begin
               end_pos_in = pos_ff;
            end else begin
               phase_in = lshs_pkg::PH_SEEK_END;
               dir_in   = 1'b1;
               level_in = 1'b1;
               timer_in = half_load;
            end
         end else begin
            pend_in  = (op == lshs_pkg::OP_CALIBRATE);
            phase_in = home_sensor ? lshs_pkg::PH_SEEK_HOME : lshs_pkg::PH_CLEAR_HOME;
            dir_in   = !home_sensor;
            level_in = 1'b1;
            timer_in = half_load;
         end
      end else if (tick) begin
         timer_in = timer_dec;
         if (timer_dec == '0) begin
            if (level_ff) begin
               level_in = 1'b0;
               timer_in = half_load;
            end else begin
               pos_in = moved_pos;
               unique case (phase_ff)
                  lshs_pkg::PH_SEEK_HOME: begin
                     level_in = 1'b1;
                     timer_in = half_load;
                     if (!home_sensor) begin
                        phase_in = lshs_pkg::PH_CLEAR_HOME;
                        dir_in   = 1'b1;
                     end
                  end
                  lshs_pkg::PH_CLEAR_HOME: begin
                     if (home_sensor) begin
                        pos_in = '0;
                        if (pend_ff) begin
                           pend_in = 1'b0;
                           if (!end_sensor) begin
                              end_pos_in = '0;
                              phase_in   = lshs_pkg::PH_IDLE;
                              tick_done  = 1'b1;
                           end else begin
                              phase_in = lshs_pkg::PH_SEEK_END;
                              dir_in   = 1'b1;
                              level_in = 1'b1;
                              timer_in = half_load;
                           end
                        end else begin
                           phase_in  = lshs_pkg::PH_IDLE;
                           tick_done = 1'b1;
                        end
                     end else begin
                        level_in = 1'b1;
                        timer_in = half_load;
                     end
                  end
                  lshs_pkg::PH_SEEK_END: begin
                     if (!end_sensor) begin
                        end_pos_in = moved_pos;
                        phase_in   = lshs_pkg::PH_IDLE;
                        tick_done  = 1'b1;
                     end else begin
                        level_in = 1'b1;
                        timer_in = half_load;
                     end
                  end
                  default: phase_in = lshs_pkg::PH_IDLE;
               endcase
            end
         end
      end
   end

   always_comb begin
      if (tick && tick_done) begin
         status = lshs_pkg::ST_DONE;
      end else if (cmd && !cfg.limits_present) begin
         status = lshs_pkg::ST_NO_LIMITS;
      end else if (cmd && busy) begin
         status = lshs_pkg::ST_BUSY;
      end else if (accepted && (op == lshs_pkg::OP_FIND_END) && !end_sensor) begin
         status = lshs_pkg::ST_DONE;
      end else begin
         status = lshs_pkg::ST_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= lshs_pkg::PH_IDLE;
         pos_ff     <= '0;
         end_pos_ff <= '0;
         timer_ff   <= '0;
         level_ff   <= 1'b0;
         dir_ff     <= 1'b0;
         pend_ff    <= 1'b0;
      end else if (fire) begin
         phase_ff   <= phase_in;
         pos_ff     <= pos_in;
         end_pos_ff <= end_pos_in;
         timer_ff   <= timer_in;
         level_ff   <= level_in;
         dir_ff     <= dir_in;
         pend_ff    <= pend_in;
      end
   end

   assign result.step_out     = level_in;
   assign result.dir_out      = dir_in;
   assign result.position     = lshs_pkg::OUT_W'(pos_in);
   assign result.end_position = lshs_pkg::OUT_W'(end_pos_in);
   assign result.busy_res     = (phase_in != lshs_pkg::PH_IDLE);
   assign result.status       = status;

`ifndef SYNTHESIS
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == lshs_pkg::PH_IDLE) |-> (!level_ff && (timer_ff == '0)))
      else $error("idle sequencer has a step or timer running");

   a_busy_timer: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != lshs_pkg::PH_IDLE) |-> (timer_ff != '0))
      else $error("running sequence has an expired half-period timer");

   a_pend_phase: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> ((phase_ff == lshs_pkg::PH_SEEK_HOME) ||
                   (phase_ff == lshs_pkg::PH_CLEAR_HOME)))
      else $error("end search pending outside the homing phases");

   a_dir_end: assert property (@(posedge clock) disable iff (reset)
      ((phase_ff == lshs_pkg::PH_SEEK_END) || (phase_ff == lshs_pkg::PH_CLEAR_HOME)) |-> dir_ff)
      else $error("moving toward home while backing off or seeking the end");
`endif

endmodule
